/* rtl/olst_pkg.sv */
package olst_pkg;

  localparam int DEPTH_DEFAULT = 64;
  // widest list index for DEPTH up to 1024
  localparam int AT_W = 10;

  localparam logic [3:0] FN_CLEAR    = 4'd0;
  localparam logic [3:0] FN_INS_HEAD = 4'd1;
  localparam logic [3:0] FN_INS_TAIL = 4'd2;
  localparam logic [3:0] FN_INS_AT   = 4'd3;
  localparam logic [3:0] FN_REM_HEAD = 4'd4;
  localparam logic [3:0] FN_REM_TAIL = 4'd5;
  localparam logic [3:0] FN_REM_AT   = 4'd6;
  localparam logic [3:0] FN_REM_KEY  = 4'd7;
  localparam logic [3:0] FN_FIND     = 4'd8;
  localparam logic [3:0] FN_READ_AT  = 4'd9;
  localparam logic [3:0] FN_COUNT    = 4'd10;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM,
    CELL_CMP,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [AT_W-1:0]  at;
    logic [31:0]      key;
    logic [63:0]      payload;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_HIT
  } state_t;

endpackage

/* rtl/olst_cell.sv */
module olst_cell
  import olst_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic        clk,
  input  cell_cmd_t   cmd,
  input  logic [31:0] left_key,
  input  logic [63:0] left_payload,
  input  logic [31:0] right_key,
  input  logic [63:0] right_payload,
  input  logic        right_match,
  output logic [31:0] key_q,
  output logic [63:0] payload_q,
  output logic        match_q
);

  localparam logic [AT_W-1:0] MY_AT = AT_W'(INDEX);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INS: begin
        if (MY_AT == cmd.at) begin
          key_q     <= cmd.key;
          payload_q <= cmd.payload;
        end else if (MY_AT > cmd.at) begin
          key_q     <= left_key;
          payload_q <= left_payload;
        end
      end
      CELL_REM: begin
        if (MY_AT >= cmd.at) begin
          key_q     <= right_key;
          payload_q <= right_payload;
        end
      end
      CELL_CMP:  match_q <= (key_q == cmd.key);
      CELL_SCAN: match_q <= right_match;
      default: ;
    endcase
  end

endmodule

/* rtl/ordered_array_list_engine_unit.sv */
// ordered list of up to DEPTH records (signed 32-bit key, 64-bit payload)
// kept in a row of cells, record i in cell i
// s_* channel takes one request word: func, position, key, payload
// m_* channel gives one result word per request: status, found key and
// payload, occupancy after the request, match count
// clear, inserts, removes by position and reads finish in S_EXEC, which
// writes the result register; key requests (remove key, find, count)
// first compare all cells at once, then shift the match flags toward cell
// 0 one per cycle, pausing while a result waits in the output register
// one request is worked on at a time; the next is taken as soon as the
// current result is in the output register, even while that word waits
// a stalled receiver holds the result register and the block waits before
// writing the next result
// reset empties the list; record contents are not cleared
module ordered_array_list_engine_unit
  import olst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // func[3:0] position[10:4] key[42:11] payload[106:43]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata   // status[2:0] found_key[34:3] found_payload[98:35]
                                 // occupancy[105:99] match_count[112:106]
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int XW = (CW > 7) ? CW : 7;

  state_t state, state_next;

  logic [3:0]  func;
  logic [6:0]  position;
  logic [31:0] key;
  logic [63:0] payload;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] hit_count, hit_count_next;
  logic [IW-1:0] where, where_next;

  logic [31:0] key_q     [DEPTH];
  logic [63:0] payload_q [DEPTH];
  logic        match_q   [DEPTH];

  cell_cmd_t cmd;

  logic        res_load;
  logic [2:0]  res_status;
  logic [31:0] res_key;
  logic [63:0] res_payload;

  logic [2:0]  o_status;
  logic [31:0] o_key;
  logic [63:0] o_payload;
  logic [6:0]  o_occ;
  logic [6:0]  o_match;

  logic          out_free;
  logic          full, empty, last;
  logic [XW-1:0] pos_x, cnt_x;

  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign last     = ((idx + CW'(1)) == count);
  assign pos_x    = XW'(position);
  assign cnt_x    = XW'(count);
  assign s_tready = (state == S_IDLE);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [31:0] lk, rk;
      logic [63:0] lp, rp;
      logic        rm;
      if (g == 0) begin : g_first
        assign lk = '0;
        assign lp = '0;
      end else begin : g_mid_l
        assign lk = key_q[g-1];
        assign lp = payload_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign rk = '0;
        assign rp = '0;
        assign rm = 1'b0;
      end else begin : g_mid_r
        assign rk = key_q[g+1];
        assign rp = payload_q[g+1];
        assign rm = match_q[g+1];
      end
      olst_cell #(.INDEX(g)) u_cell (
        .clk           (clk),
        .cmd           (cmd),
        .left_key      (lk),
        .left_payload  (lp),
        .right_key     (rk),
        .right_payload (rp),
        .right_match   (rm),
        .key_q         (key_q[g]),
        .payload_q     (payload_q[g]),
        .match_q       (match_q[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func     <= s_tdata[3:0];
      position <= s_tdata[10:4];
      key      <= s_tdata[42:11];
      payload  <= s_tdata[106:43];
    end
    idx       <= idx_next;
    hit_count <= hit_count_next;
    where     <= where_next;
    if (res_load) begin
      o_status  <= res_status;
      o_key     <= res_key;
      o_payload <= res_payload;
      o_occ     <= 7'(count_next);
      o_match   <= 7'(hit_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {7'd0, o_match, o_occ, o_payload, o_key, o_status};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          if ((func == FN_REM_KEY || func == FN_FIND) && !empty) begin
            state_next = S_SCAN;
          end else if (func == FN_COUNT && !empty) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (func != FN_COUNT && match_q[0]) begin
            state_next = S_HIT;
          end else if (last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_HIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // cell commands, counters and result
  always_comb begin
    cmd            = '{op: CELL_HOLD, at: '0, key: key, payload: payload};
    count_next     = count;
    idx_next       = idx;
    hit_count_next = hit_count;
    where_next     = where;
    res_load       = 1'b0;
    res_status     = ST_OK;
    res_key        = '0;
    res_payload    = '0;
    case (state)
      S_EXEC: begin
        idx_next       = '0;
        hit_count_next = '0;
        if (out_free) begin
          res_load = 1'b1;
          case (func)
            FN_CLEAR: count_next = '0;
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_AT: begin
              if (full) begin
                res_status = ST_FULL;
              end else if (func == FN_INS_AT && pos_x > cnt_x) begin
                res_status = ST_RANGE;
              end else begin
                cmd.op = CELL_INS;
                if (func == FN_INS_TAIL) cmd.at = AT_W'(count);
                else if (func == FN_INS_AT) cmd.at = AT_W'(position);
                count_next = count + CW'(1);
              end
            end
            FN_REM_HEAD, FN_REM_TAIL, FN_REM_AT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (func == FN_REM_AT && pos_x >= cnt_x) begin
                res_status = ST_RANGE;
              end else begin
                if (func != FN_REM_TAIL) cmd.op = CELL_REM;
                if (func == FN_REM_AT) cmd.at = AT_W'(position);
                count_next = count - CW'(1);
              end
            end
            FN_READ_AT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                res_status = ST_RANGE;
              end else begin
                res_key     = key_q[pos_x[IW-1:0]];
                res_payload = payload_q[pos_x[IW-1:0]];
              end
            end
            FN_REM_KEY, FN_FIND: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_load = 1'b0;
                cmd.op   = CELL_CMP;
              end
            end
            FN_COUNT: begin
              if (!empty) begin
                res_load = 1'b0;
                cmd.op   = CELL_CMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (out_free) begin
          // cell 0 holds the flag of list position idx
          cmd.op   = CELL_SCAN;
          idx_next = idx + CW'(1);
          if (func == FN_COUNT) begin
            hit_count_next = hit_count + CW'(match_q[0]);
            res_load       = last;
          end else if (match_q[0]) begin
            where_next = IW'(idx);
          end else if (last) begin
            res_load   = 1'b1;
            res_status = ST_NOTFOUND;
          end
        end
      end
      S_HIT: begin
        if (out_free) begin
          res_load = 1'b1;
          if (func == FN_FIND) begin
            res_key     = key_q[where];
            res_payload = payload_q[where];
          end else begin
            cmd.op     = CELL_REM;
            cmd.at     = AT_W'(where);
            count_next = count - CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("list count above depth");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |=> count == $past(count))
    else $error("list count changed while idle");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_EXEC)
    else $error("accepted request not executed");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result written over a waiting word");

endmodule
